// ===== sv/yuv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Shared types, coefficients and helpers of the 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 19;
	localparam int DIFF_W  = 9;
	localparam int SUM_W   = 28;
	localparam int LANES   = 4;

	localparam int COEF_DROP  = 10;
	localparam int FULL_SHIFT = 16;
	localparam int RED_SHIFT  = 6;

	localparam int K_Y_FULL   = 76283;
	localparam int K_CRV_FULL = 104595;
	localparam int K_CBU_FULL = 132251;
	localparam int K_CGU_FULL = 25624;
	localparam int K_CGV_FULL = 53280;
	localparam int K_OFF_FULL = 32768;

	localparam logic signed [COEF_W-1:0] K_Y_F   = COEF_W'(K_Y_FULL);
	localparam logic signed [COEF_W-1:0] K_CRV_F = COEF_W'(K_CRV_FULL);
	localparam logic signed [COEF_W-1:0] K_CBU_F = COEF_W'(K_CBU_FULL);
	localparam logic signed [COEF_W-1:0] K_CGU_F = COEF_W'(K_CGU_FULL);
	localparam logic signed [COEF_W-1:0] K_CGV_F = COEF_W'(K_CGV_FULL);
	localparam logic signed [SUM_W-1:0]  K_OFF_F = SUM_W'(K_OFF_FULL);

	localparam logic signed [COEF_W-1:0] K_Y_R   = COEF_W'(K_Y_FULL >> COEF_DROP);
	localparam logic signed [COEF_W-1:0] K_CRV_R = COEF_W'(K_CRV_FULL >> COEF_DROP);
	localparam logic signed [COEF_W-1:0] K_CBU_R = COEF_W'(K_CBU_FULL >> COEF_DROP);
	localparam logic signed [COEF_W-1:0] K_CGU_R = COEF_W'(K_CGU_FULL >> COEF_DROP);
	localparam logic signed [COEF_W-1:0] K_CGV_R = COEF_W'(K_CGV_FULL >> COEF_DROP);
	localparam logic signed [SUM_W-1:0]  K_OFF_R = SUM_W'(K_OFF_FULL >> COEF_DROP);

	localparam logic signed [DIFF_W-1:0] LUMA_BIAS   = DIFF_W'(16);
	localparam logic signed [DIFF_W-1:0] CHROMA_BIAS = DIFF_W'(128);

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic reduced;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] red;
		logic signed [SUM_W-1:0] green;
		logic signed [SUM_W-1:0] blue;
	} chroma_terms_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	function automatic logic signed [DIFF_W-1:0] unbias(
		input logic [PIX_W-1:0] val,
		input logic signed [DIFF_W-1:0] bias
	);
		return $signed({1'b0, val}) - bias;
	endfunction

	function automatic logic [PIX_W-1:0] shift_clamp(
		input logic signed [SUM_W-1:0] sum,
		input logic reduced
	);
		logic signed [SUM_W-1:0] sh;
		sh = reduced ? (sum >>> RED_SHIFT) : (sum >>> FULL_SHIFT);
		if (sh < 0) begin
			return '0;
		end else if (sh > SUM_W'(255)) begin
			return '1;
		end
		return sh[PIX_W-1:0];
	endfunction

endpackage

// ===== sv/yuv2rgb_in_if.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_in_if
// Channel carrying one 2x2 block of 4:2:0 samples.
// ----------------------------------------------------------------------------
interface yuv2rgb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_top_left;
	logic [7:0] luma_top_right;
	logic [7:0] luma_bottom_left;
	logic [7:0] luma_bottom_right;
	logic [7:0] chroma_blue;
	logic [7:0] chroma_red;

	modport source (
		output valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, chroma_blue, chroma_red,
		input  ready
	);
	modport sink (
		input  valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, chroma_blue, chroma_red,
		output ready
	);
endinterface

// ===== sv/yuv2rgb_out_if.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_out_if
// Channel carrying four RGB pixels of one converted block.
// ----------------------------------------------------------------------------
interface yuv2rgb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_top_left;
	logic [7:0] green_top_left;
	logic [7:0] blue_top_left;
	logic [7:0] red_top_right;
	logic [7:0] green_top_right;
	logic [7:0] blue_top_right;
	logic [7:0] red_bottom_left;
	logic [7:0] green_bottom_left;
	logic [7:0] blue_bottom_left;
	logic [7:0] red_bottom_right;
	logic [7:0] green_bottom_right;
	logic [7:0] blue_bottom_right;

	modport source (
		output valid,
		       red_top_left, green_top_left, blue_top_left,
		       red_top_right, green_top_right, blue_top_right,
		       red_bottom_left, green_bottom_left, blue_bottom_left,
		       red_bottom_right, green_bottom_right, blue_bottom_right,
		input  ready
	);
	modport sink (
		input  valid,
		       red_top_left, green_top_left, blue_top_left,
		       red_top_right, green_top_right, blue_top_right,
		       red_bottom_left, green_bottom_left, blue_bottom_left,
		       red_bottom_right, green_bottom_right, blue_bottom_right,
		output ready
	);
endinterface

// ===== sv/yuv2rgb_chroma.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_chroma
// Shared chroma products and per-color chroma terms of one block.
// ----------------------------------------------------------------------------
module yuv2rgb_chroma
	import yuv2rgb_pkg::*;
(
	input  logic            clk,
	input  pipe_ctl_t       ctl,
	input  logic [PIX_W-1:0] chroma_blue,
	input  logic [PIX_W-1:0] chroma_red,
	output chroma_terms_t   terms
);

	logic signed [DIFF_W-1:0] cb;
	logic signed [DIFF_W-1:0] cr;
	logic signed [COEF_W-1:0] k_crv;
	logic signed [COEF_W-1:0] k_cbu;
	logic signed [COEF_W-1:0] k_cgu;
	logic signed [COEF_W-1:0] k_cgv;
	logic signed [SUM_W-1:0]  k_off;

	logic signed [SUM_W-1:0] crv_s1;
	logic signed [SUM_W-1:0] cbu_s1;
	logic signed [SUM_W-1:0] cgu_s1;
	logic signed [SUM_W-1:0] cgv_s1;
	chroma_terms_t           terms_s2;

	assign cb    = unbias(chroma_blue, CHROMA_BIAS);
	assign cr    = unbias(chroma_red, CHROMA_BIAS);
	assign k_crv = ctl.reduced ? K_CRV_R : K_CRV_F;
	assign k_cbu = ctl.reduced ? K_CBU_R : K_CBU_F;
	assign k_cgu = ctl.reduced ? K_CGU_R : K_CGU_F;
	assign k_cgv = ctl.reduced ? K_CGV_R : K_CGV_F;
	assign k_off = ctl.reduced ? K_OFF_R : K_OFF_F;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			crv_s1 <= k_crv * cr;
			cbu_s1 <= k_cbu * cb;
			cgu_s1 <= k_cgu * cb;
			cgv_s1 <= k_cgv * cr;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			terms_s2.red   <= crv_s1;
			terms_s2.green <= k_off - cgu_s1 - cgv_s1;
			terms_s2.blue  <= cbu_s1 + k_off;
		end
	end

	assign terms = terms_s2;

endmodule

// ===== sv/yuv2rgb_lane.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_lane
// One pixel lane: luma product, sum with chroma terms, shift and clamp.
// ----------------------------------------------------------------------------
module yuv2rgb_lane
	import yuv2rgb_pkg::*;
(
	input  logic             clk,
	input  pipe_ctl_t        ctl,
	input  logic [PIX_W-1:0] luma,
	input  chroma_terms_t    terms,
	output pixel_t           pixel
);

	logic signed [DIFF_W-1:0] ys;
	logic signed [COEF_W-1:0] k_y;
	logic signed [SUM_W-1:0]  y_s1;
	logic signed [SUM_W-1:0]  y_s2;

	assign ys  = unbias(luma, LUMA_BIAS);
	assign k_y = ctl.reduced ? K_Y_R : K_Y_F;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			y_s1 <= k_y * ys;
		end
		if (ctl.en_s2) begin
			y_s2 <= y_s1;
		end
	end

	always_comb begin
		pixel.red   = shift_clamp(y_s2 + terms.red, ctl.reduced);
		pixel.green = shift_clamp(y_s2 + terms.green, ctl.reduced);
		pixel.blue  = shift_clamp(y_s2 + terms.blue, ctl.reduced);
	end

endmodule

// ===== sv/yuv420_block_to_rgb_top.sv =====
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_top
// 2x2 block of 4:2:0 video to four BT.601 RGB pixels, four lanes wide.
//
//   channel | dir | handshake       | content
//   --------+-----+-----------------+----------------------------------------
//   yuv     | in  | valid / ready   | four luma samples, blue and red chroma
//   rgb     | out | valid / ready   | red, green, blue of the four pixels
//   cfg     | in  | cfg_wr_en       | reduced_precision mode bit
//
// One block per clock while rgb.ready does not stall; rgb.valid follows the stages:
// the multiply stage loads at accept, then the chroma-term stage and the
// output register follow.
// arst_n clears the stage valids and the mode bit (full precision).
// Each stage advances when it is empty or its successor advances, so bubbles
// fill while the output holds a stalled item.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_top
	import yuv2rgb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	yuv2rgb_in_if.sink     yuv,
	yuv2rgb_out_if.source  rgb
);

	logic      mode_q;
	logic      valid_s1;
	logic      valid_s2;
	logic      out_valid_q;
	logic      en_s1;
	logic      en_s2;
	logic      en_out;
	pipe_ctl_t ctl;

	logic [PIX_W-1:0] luma [LANES];
	pixel_t           lane_px [LANES];
	pixel_t           px_q [LANES];
	chroma_terms_t    terms;

	assign en_out = !out_valid_q || rgb.ready;
	assign en_s2  = !valid_s2 || en_out;
	assign en_s1  = !valid_s1 || en_s2;

	assign ctl.en_s1   = en_s1;
	assign ctl.en_s2   = en_s2;
	assign ctl.reduced = mode_q;

	assign yuv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= yuv.valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign luma[0] = yuv.luma_top_left;
	assign luma[1] = yuv.luma_top_right;
	assign luma[2] = yuv.luma_bottom_left;
	assign luma[3] = yuv.luma_bottom_right;

	yuv2rgb_chroma u_chroma (
		.clk         (clk),
		.ctl         (ctl),
		.chroma_blue (yuv.chroma_blue),
		.chroma_red  (yuv.chroma_red),
		.terms       (terms)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		yuv2rgb_lane u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.luma  (luma[i]),
			.terms (terms),
			.pixel (lane_px[i])
		);
	end

	// merge the lanes into the output item
	always_ff @(posedge clk) begin
		if (en_out) begin
			for (int i = 0; i < LANES; i++) begin
				px_q[i] <= lane_px[i];
			end
		end
	end

	assign rgb.valid              = out_valid_q;
	assign rgb.red_top_left       = px_q[0].red;
	assign rgb.green_top_left     = px_q[0].green;
	assign rgb.blue_top_left      = px_q[0].blue;
	assign rgb.red_top_right      = px_q[1].red;
	assign rgb.green_top_right    = px_q[1].green;
	assign rgb.blue_top_right     = px_q[1].blue;
	assign rgb.red_bottom_left    = px_q[2].red;
	assign rgb.green_bottom_left  = px_q[2].green;
	assign rgb.blue_bottom_left   = px_q[2].blue;
	assign rgb.red_bottom_right   = px_q[3].red;
	assign rgb.green_bottom_right = px_q[3].green;
	assign rgb.blue_bottom_right  = px_q[3].blue;

endmodule

// ===== tb/yuv420_block_to_rgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_checker
// Watches the yuv and rgb channels and the mode write port. Each accepted
// 2x2 block is converted by an independent fixed-point model under the mode
// in force. Each accepted rgb item is then compared field by field with the
// oldest expected quad. Mismatches and unexpected items are counted and
// passed to the testbench top.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_checker
	import yuv2rgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	yuv2rgb_in_if       yuv,
	yuv2rgb_out_if      rgb,
	output int unsigned fail_count,
	output int unsigned blocks_in_flight,
	output int unsigned blocks_checked
);

	typedef struct packed {
		pixel_t top_left;
		pixel_t top_right;
		pixel_t bottom_left;
		pixel_t bottom_right;
	} rgb_quad_t;

	localparam int MAX_REPORTS = 10;
	localparam int FIELDS      = 12;

	string field_name [FIELDS] = '{
		"red_top_left", "green_top_left", "blue_top_left",
		"red_top_right", "green_top_right", "blue_top_right",
		"red_bottom_left", "green_bottom_left", "blue_bottom_left",
		"red_bottom_right", "green_bottom_right", "blue_bottom_right"
	};

	logic        reduced = 1'b0;
	rgb_quad_t   expected_quads [$];
	int unsigned errors  = 0;
	int unsigned checked = 0;

	initial begin
		fail_count       = 0;
		blocks_in_flight = 0;
		blocks_checked   = 0;
	end

	function automatic logic [PIX_W-1:0] shift_saturate(input longint sum, input int amount);
		longint v;
		v = sum >>> amount;
		if (v < 0) begin
			return '0;
		end else if (v > 255) begin
			return '1;
		end
		return PIX_W'(v);
	endfunction

	function automatic pixel_t convert_pixel(
		input logic [PIX_W-1:0] luma,
		input longint           cb,
		input longint           cr,
		input logic             rp
	);
		longint ky, kcrv, kcbu, kcgu, kcgv, koff, ys;
		int     drop, amount;
		pixel_t px;
		drop   = rp ? COEF_DROP : 0;
		amount = rp ? RED_SHIFT : FULL_SHIFT;
		ky     = longint'(K_Y_FULL) >> drop;
		kcrv   = longint'(K_CRV_FULL) >> drop;
		kcbu   = longint'(K_CBU_FULL) >> drop;
		kcgu   = longint'(K_CGU_FULL) >> drop;
		kcgv   = longint'(K_CGV_FULL) >> drop;
		koff   = longint'(K_OFF_FULL) >> drop;
		ys       = ky * (longint'(luma) - longint'(LUMA_BIAS));
		px.red   = shift_saturate(ys + kcrv * cr, amount);
		px.green = shift_saturate(ys - kcgu * cb - kcgv * cr + koff, amount);
		px.blue  = shift_saturate(ys + kcbu * cb + koff, amount);
		return px;
	endfunction

	function automatic rgb_quad_t convert_block(input logic rp);
		longint    cb, cr;
		rgb_quad_t q;
		cb = longint'(yuv.chroma_blue) - longint'(CHROMA_BIAS);
		cr = longint'(yuv.chroma_red) - longint'(CHROMA_BIAS);
		q.top_left     = convert_pixel(yuv.luma_top_left, cb, cr, rp);
		q.top_right    = convert_pixel(yuv.luma_top_right, cb, cr, rp);
		q.bottom_left  = convert_pixel(yuv.luma_bottom_left, cb, cr, rp);
		q.bottom_right = convert_pixel(yuv.luma_bottom_right, cb, cr, rp);
		return q;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_quad_t seen, want;
		if (!arst_n) begin
			reduced = 1'b0;
			expected_quads.delete();
		end else begin
			if (rgb.valid && rgb.ready) begin
				seen = {
					rgb.red_top_left, rgb.green_top_left, rgb.blue_top_left,
					rgb.red_top_right, rgb.green_top_right, rgb.blue_top_right,
					rgb.red_bottom_left, rgb.green_bottom_left, rgb.blue_bottom_left,
					rgb.red_bottom_right, rgb.green_bottom_right, rgb.blue_bottom_right
				};
				if (expected_quads.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: rgb item with no block pending: %h", $time, seen);
					end
				end else begin
					want = expected_quads.pop_front();
					checked++;
					for (int f = 0; f < FIELDS; f++) begin
						if (seen[8*(FIELDS-1-f) +: 8] !== want[8*(FIELDS-1-f) +: 8]) begin
							errors++;
							if (errors <= MAX_REPORTS) begin
								$display("%0t: %s expected %0d got %0d", $time,
									field_name[f], want[8*(FIELDS-1-f) +: 8],
									seen[8*(FIELDS-1-f) +: 8]);
							end
						end
					end
				end
			end
			if (yuv.valid && yuv.ready) begin
				expected_quads.push_back(convert_block(reduced));
			end
			if (cfg_wr_en) begin
				reduced = cfg_wr_data;
			end
		end
		fail_count       <= errors;
		blocks_in_flight <= expected_quads.size();
		blocks_checked   <= checked;
	end

endmodule

// ===== tb/yuv420_block_to_rgb_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb_top_tb
// Block-level test of the 4:2:0 to RGB converter. Runs four mode phases
// (full, reduced, full, reduced): directed corner blocks in the first two,
// then random blocks with random source gaps and sink stalls. The checker
// beside the DUT predicts and compares every rgb item.
// ----------------------------------------------------------------------------
module yuv420_block_to_rgb_top_tb;
	import yuv2rgb_pkg::*;

	typedef struct packed {
		logic [7:0] y_tl;
		logic [7:0] y_tr;
		logic [7:0] y_bl;
		logic [7:0] y_br;
		logic [7:0] cb;
		logic [7:0] cr;
	} yuv_block_t;

	localparam logic MODE_FULL    = 1'b0;
	localparam logic MODE_REDUCED = 1'b1;

	localparam int PHASES           = 4;
	localparam int RANDOM_PER_PHASE = 457;
	localparam int DIRECTED_PHASES  = 2;
	localparam int DRAIN_CYCLES     = 8;
	localparam int SETTLE_CYCLES    = 4;
	localparam int CYCLE_LIMIT      = 500000;

	localparam logic PHASE_MODE [PHASES] = '{MODE_FULL, MODE_REDUCED, MODE_FULL, MODE_REDUCED};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic cfg_wr_data;

	yuv2rgb_in_if  yuv ();
	yuv2rgb_out_if rgb ();

	int unsigned fail_count;
	int unsigned blocks_in_flight;
	int unsigned blocks_checked;

	logic        mode_now    = MODE_FULL;
	int unsigned full_blocks = 0;
	int unsigned red_blocks  = 0;
	int unsigned mode_writes = 0;
	int unsigned cycles      = 0;
	bit          src_steady  = 1'b0;
	bit          snk_steady  = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	yuv420_block_to_rgb_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.yuv         (yuv),
		.rgb         (rgb)
	);

	yuv420_block_to_rgb_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.yuv              (yuv),
		.rgb              (rgb),
		.fail_count       (fail_count),
		.blocks_in_flight (blocks_in_flight),
		.blocks_checked   (blocks_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int draw_wait(ref bit steady);
		if ($urandom_range(0, 39) == 0) begin
			steady = !steady;
		end
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic logic [7:0] pick_sample(input bit video_range);
		if (video_range) begin
			return 8'($urandom_range(16, 240));
		end
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd235;
			4: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic yuv_block_t random_block();
		yuv_block_t b;
		bit         video_range;
		video_range = 1'($urandom_range(0, 1));
		b.y_tl = pick_sample(video_range);
		b.y_tr = pick_sample(video_range);
		b.y_bl = pick_sample(video_range);
		b.y_br = pick_sample(video_range);
		b.cb   = pick_sample(video_range);
		b.cr   = pick_sample(video_range);
		return b;
	endfunction

	task automatic send_block(input yuv_block_t b);
		int gap;
		gap = draw_wait(src_steady);
		if (gap > 0) begin
			yuv.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		yuv.valid             <= 1'b1;
		yuv.luma_top_left     <= b.y_tl;
		yuv.luma_top_right    <= b.y_tr;
		yuv.luma_bottom_left  <= b.y_bl;
		yuv.luma_bottom_right <= b.y_br;
		yuv.chroma_blue       <= b.cb;
		yuv.chroma_red        <= b.cr;
		@(posedge clk);
		while (!yuv.ready) @(posedge clk);
		if (mode_now == MODE_REDUCED) begin
			red_blocks++;
		end else begin
			full_blocks++;
		end
	endtask

	task automatic write_mode(input logic value);
		yuv.valid <= 1'b0;
		@(posedge clk);
		while (blocks_in_flight != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_now = value;
		mode_writes++;
	endtask

	task automatic run_directed();
		send_block('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
		send_block('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
		send_block('{8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128});
		send_block('{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128});
		send_block('{8'd0, 8'd255, 8'd16, 8'd235, 8'd128, 8'd128});
		send_block('{8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0});
		send_block('{8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255});
		// red chroma alone drives green through the 0.813 term
		send_block('{8'd16, 8'd80, 8'd160, 8'd235, 8'd128, 8'd255});
		send_block('{8'd16, 8'd80, 8'd160, 8'd235, 8'd128, 8'd0});
		send_block('{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255});
		send_block('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55});
		send_block('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA});
	endtask

	initial begin
		int stall;
		rgb.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_wait(snk_steady);
			if (stall > 0) begin
				rgb.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb.ready <= 1'b1;
			@(posedge clk);
			while (!rgb.valid) @(posedge clk);
		end
	end

	initial begin
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = MODE_FULL;
		yuv.valid             = 1'b0;
		yuv.luma_top_left     = '0;
		yuv.luma_top_right    = '0;
		yuv.luma_bottom_left  = '0;
		yuv.luma_bottom_right = '0;
		yuv.chroma_blue       = '0;
		yuv.chroma_red        = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				write_mode(PHASE_MODE[phase]);
			end
			if (phase < DIRECTED_PHASES) begin
				run_directed();
			end
			repeat (RANDOM_PER_PHASE) send_block(random_block());
		end
		yuv.valid <= 1'b0;
		@(posedge clk);
		while (blocks_in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d blocks in full and %0d in reduced precision, %0d mode writes.",
			full_blocks, red_blocks, mode_writes);
		$display("Compared %0d rgb items with random gaps and stalls on both channels.",
			blocks_checked);
		if (fail_count == 0 && blocks_in_flight == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures, %0d blocks unanswered", fail_count, blocks_in_flight);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
